/* rtl/core/hpg_pkg.sv */
package hpg_pkg;

  // Field widths
  localparam int HASH_W    = 32;
  localparam int SLOT_W    = 5;
  localparam int TAG_W     = 4;
  localparam int ROW_IDX_W = 6;

  // Default capacity
  localparam int DEF_MAX_ROWS  = 64;
  localparam int DEF_MAX_PARTS = 16;

  // Remainder unit: hash bits retired per cycle
  localparam int MOD_BITS  = 8;
  localparam int MOD_STEPS = HASH_W / MOD_BITS;
  localparam int MOD_CNT_W = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;

  // One stored row
  typedef struct packed {
    logic                 valid;
    logic [TAG_W-1:0]     tag;
    logic [ROW_IDX_W-1:0] idx;
  } cell_t;

  // Broadcast command from the controller to every cell
  typedef struct packed {
    logic                 ins;
    logic                 shift;
    logic [TAG_W-1:0]     tag;
    logic [ROW_IDX_W-1:0] idx;
  } cell_cmd_t;

endpackage

/* rtl/core/hpg_ifs.sv */
interface hpg_in_if;
  import hpg_pkg::*;
  logic              valid;
  logic              ready;
  logic [HASH_W-1:0] key_hash;
  logic              end_of_table;
  modport source (output valid, key_hash, end_of_table, input ready);
  modport sink   (input valid, key_hash, end_of_table, output ready);
endinterface

interface hpg_out_if;
  import hpg_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [ROW_IDX_W-1:0] row_index;
  logic [TAG_W-1:0]     part_number;
  logic                 part_end;
  logic                 table_end;
  logic                 overflowed;
  modport source (output valid, row_index, part_number, part_end, table_end, overflowed,
                  input ready);
  modport sink   (input valid, row_index, part_number, part_end, table_end, overflowed,
                  output ready);
endinterface

interface hpg_cfg_if;
  import hpg_pkg::*;
  logic              valid;
  logic              ready;
  logic [SLOT_W-1:0] num_slots;
  modport source (output valid, num_slots, input ready);
  modport sink   (input valid, num_slots, output ready);
endinterface

/* rtl/core/hash_partition_row_grouper.sv */
// Hash partition row grouper.
// rows (sink): one word per table row, key_hash plus end_of_table. Rows are
// numbered from 0 in arrival order and tagged with key_hash modulo num_slots (clamped to 1..MAX_PARTS).
// cfg (sink): writes num_slots; always ready, write only while idle.
// groups (source): after the row marked end_of_table, one word per stored row,
// grouped by partition in ascending order, row order kept inside a partition,
// with part_end, table_end and overflowed flags.
// Each accepted row is taken in, passed through the remainder unit (8 hash
// bits a cycle) and then inserted into the sorted chain of cells.
// A row arriving when MAX_ROWS rows are stored is dropped and sets overflowed.
// The drain starts the cycle after the last row is inserted or dropped and
// shifts the chain one word a cycle; a stalled receiver holds the chain.
// rows.ready is low from acceptance until the row is stored and during the
// drain. After the last drain word the block is empty and ready again.
// Reset (rst, synchronous) empties the chain, clears the counters and sets
// num_slots to 1.
module hash_partition_row_grouper #(
  parameter int MAX_ROWS  = hpg_pkg::DEF_MAX_ROWS,
  parameter int MAX_PARTS = hpg_pkg::DEF_MAX_PARTS
) (
  input  logic             clk,
  input  logic             rst,
  hpg_in_if.sink           rows,
  hpg_cfg_if.sink          cfg,
  hpg_out_if.source        groups
);
  import hpg_pkg::*;

  localparam int RCNT_W = $clog2(MAX_ROWS + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_MOD   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]        state;
  logic [SLOT_W-1:0] num_slots;
  logic [SLOT_W-1:0] eff_slots;
  logic [RCNT_W-1:0] rows_seen;
  logic              overflow;
  logic              last_q;
  logic              full;
  logic              row_acc;
  logic              out_acc;
  logic              mod_start;
  logic              mod_done;
  logic [TAG_W-1:0]  mod_tag;
  cell_cmd_t         cmd;
  cell_t             chain [MAX_ROWS+1];
  logic [MAX_ROWS-1:0] gt_v;

  // Configuration register
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      num_slots <= SLOT_W'(1);
    end else if (cfg.valid) begin
      num_slots <= cfg.num_slots;
    end
  end

  // Clamp the slot count to 1..MAX_PARTS
  always_comb begin
    if (num_slots == '0) begin
      eff_slots = SLOT_W'(1);
    end else if (32'(num_slots) > MAX_PARTS) begin
      eff_slots = SLOT_W'(MAX_PARTS);
    end else begin
      eff_slots = num_slots;
    end
  end

  assign full      = (32'(rows_seen) == MAX_ROWS);
  assign rows.ready = (state == ST_IDLE);
  assign row_acc   = rows.valid && rows.ready;
  assign mod_start = row_acc && !full;
  assign out_acc   = groups.valid && groups.ready;

  hpg_mod u_mod (
    .clk     (clk),
    .rst     (rst),
    .start   (mod_start),
    .hash    (rows.key_hash),
    .slots   (eff_slots),
    .done    (mod_done),
    .rem_out (mod_tag)
  );

  // Broadcast command to the cells
  always_comb begin
    cmd.ins   = (state == ST_MOD) && mod_done;
    cmd.shift = (state == ST_DRAIN) && groups.ready;
    cmd.tag   = mod_tag;
    cmd.idx   = ROW_IDX_W'(rows_seen);
  end

  // Row of cells, kept sorted by tag then arrival
  assign chain[MAX_ROWS] = '0;
  for (genvar i = 0; i < MAX_ROWS; i++) begin : g_cell
    cell_t prev_c;
    logic  prev_gt;
    if (i == 0) begin : g_head
      assign prev_c  = '{valid: 1'b1, tag: '0, idx: '0};
      assign prev_gt = 1'b0;
    end else begin : g_body
      assign prev_c  = chain[i-1];
      assign prev_gt = gt_v[i-1];
    end
    hpg_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .cmd     (cmd),
      .prev    (prev_c),
      .prev_gt (prev_gt),
      .next_in (chain[i+1]),
      .q       (chain[i]),
      .gt      (gt_v[i])
    );
  end

  // Sequencer: accept, remainder, insert, drain
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rows_seen <= '0;
      overflow  <= 1'b0;
      last_q    <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (row_acc) begin
            last_q <= rows.end_of_table;
            if (full) begin
              overflow <= 1'b1;
              state    <= rows.end_of_table ? ST_DRAIN : ST_IDLE;
            end else begin
              state <= ST_MOD;
            end
          end
        end
        ST_MOD: begin
          if (mod_done) begin
            rows_seen <= rows_seen + 1'b1;
            state     <= last_q ? ST_DRAIN : ST_IDLE;
          end
        end
        ST_DRAIN: begin
          if (out_acc && groups.table_end) begin
            rows_seen <= '0;
            overflow  <= 1'b0;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Result word straight from the head of the chain
  assign groups.valid       = (state == ST_DRAIN);
  assign groups.row_index   = chain[0].idx;
  assign groups.part_number = chain[0].tag;
  assign groups.table_end   = !chain[1].valid;
  assign groups.part_end    = !chain[1].valid || (chain[1].tag != chain[0].tag);
  assign groups.overflowed  = overflow;

  // Checks
  a_drain_has_row: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAIN) |-> chain[0].valid)
    else $error("drain with empty chain head");

  a_rows_bounded: assert property (@(posedge clk) disable iff (rst)
    32'(rows_seen) <= MAX_ROWS)
    else $error("row count beyond capacity");

  a_drain_clears: assert property (@(posedge clk) disable iff (rst)
    (out_acc && groups.table_end) |=> (rows_seen == '0 && !overflow && !chain[0].valid))
    else $error("table not cleared after drain");

  a_done_in_mod: assert property (@(posedge clk) disable iff (rst)
    mod_done |-> (state == ST_MOD))
    else $error("remainder finished outside insert phase");

  a_head_order: assert property (@(posedge clk) disable iff (rst)
    chain[1].valid |-> (chain[0].valid && chain[0].tag <= chain[1].tag))
    else $error("chain head out of order");

endmodule

/* rtl/core/hpg_mod.sv */
module hpg_mod (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [hpg_pkg::HASH_W-1:0] hash,
  input  logic [hpg_pkg::SLOT_W-1:0] slots,
  output logic                       done,
  output logic [hpg_pkg::TAG_W-1:0]  rem_out
);
  import hpg_pkg::*;

  logic                 busy;
  logic [MOD_CNT_W-1:0] cnt;
  logic [HASH_W-1:0]    sh;
  logic [HASH_W-1:0]    sh_next;
  logic [SLOT_W-1:0]    rem;
  logic [SLOT_W-1:0]    rem_next;
  logic [SLOT_W-1:0]    slots_q;

  // Restoring remainder, a few hash bits per cycle, most significant first
  always_comb begin
    rem_next = rem;
    sh_next  = sh;
    for (int i = 0; i < MOD_BITS; i++) begin
      rem_next = {rem_next[SLOT_W-2:0], sh_next[HASH_W-1]};
      sh_next  = {sh_next[HASH_W-2:0], 1'b0};
      if (rem_next >= slots_q) begin
        rem_next = rem_next - slots_q;
      end
    end
  end

  // Load on start, advance while busy, flag the final step
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy    <= 1'b1;
        cnt     <= '0;
        sh      <= hash;
        rem     <= '0;
        slots_q <= slots;
      end else if (busy) begin
        sh  <= sh_next;
        rem <= rem_next;
        cnt <= cnt + 1'b1;
        if (cnt == MOD_CNT_W'(MOD_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rem_out = rem[TAG_W-1:0];

endmodule

/* rtl/core/hpg_cell.sv */
module hpg_cell (
  input  logic               clk,
  input  logic               rst,
  input  hpg_pkg::cell_cmd_t cmd,
  input  hpg_pkg::cell_t     prev,
  input  logic               prev_gt,
  input  hpg_pkg::cell_t     next_in,
  output hpg_pkg::cell_t     q,
  output logic               gt
);
  import hpg_pkg::*;

  // Row here sorts after the incoming row
  assign gt = q.valid && (q.tag > cmd.tag);

  // Shift toward the head on drain; on insert take the upper neighbour or the new row
  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (cmd.shift) begin
      q <= next_in;
    end else if (cmd.ins) begin
      if (prev_gt) begin
        q <= prev;
      end else if ((gt || !q.valid) && prev.valid) begin
        q <= '{valid: 1'b1, tag: cmd.tag, idx: cmd.idx};
      end
    end
  end

endmodule
